FILE: hdl/bhr_pkg.sv
// Shared types and constants of the bicubic height resampler.
// Used by every module of the block; depends on nothing.
package bhr_pkg;

    localparam int DEF_MAX_SIDE    = 256;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int GUARD_BITS      = 2;

    localparam int COORD_W     = 8;
    localparam int VALUE_W     = 16;
    localparam int TARGET_W    = 12;
    localparam int HEIGHT_W    = 16;
    localparam int STEP_W      = 24;
    localparam int SIZE_W      = 9;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_COLUMNS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_ROWS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_X         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_Y         = 3'd3;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;

    // pass index of the column cubic, after the four row cubics
    localparam logic [2:0] COL_PASS = 3'd4;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_DRAIN,
        B_CALC,
        B_ROUND
    } t_back_state;

endpackage

FILE: hdl/bicubic_height_resampler_unit.sv
// Top level of the bicubic height resampler: front end, item queue, back end.
// Depends on bhr_pkg, bhr_front, bhr_queue and bhr_back.
//
// Items enter with start while busy is low. A write item (operation 0) stores one
// source sample and gives no result; the back end takes it without leaving its idle
// state. A compute item (operation 1) gives one height on o_height, marked by
// o_strobe for exactly one cycle, after the position multiply, the queue, a read of
// the 4x4 window through the single frame store port, five cubic passes on the one
// shared multiplier, and rounding. The receiver cannot stall; results come out in
// item order. busy rises when the two-entry queue and the input stage are full.
// Reads of never-written samples return whatever the store holds.
module bicubic_height_resampler_unit import bhr_pkg::*; #(
    parameter int MAX_SIDE    = DEF_MAX_SIDE,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_operation,
    input  logic [COORD_W-1:0]     i_source_col,
    input  logic [COORD_W-1:0]     i_source_row,
    input  logic [VALUE_W-1:0]     i_sample_value,
    input  logic [TARGET_W-1:0]    i_target_col,
    input  logic [TARGET_W-1:0]    i_target_row,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_strobe,
    output logic [HEIGHT_W-1:0]    o_height
);

    localparam int ITEM_W = 1 + 2*$clog2(MAX_SIDE) + SAMPLE_BITS + 2*$clog2(MAX_SIDE+1)
                            + 2*(TARGET_W+STEP_W);

    logic              q_push, q_pop, q_full, q_empty;
    logic [ITEM_W-1:0] q_in, q_out;

    bhr_front #(
        .MAX_SIDE    (MAX_SIDE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_operation    (i_operation),
        .i_source_col   (i_source_col),
        .i_source_row   (i_source_row),
        .i_sample_value (i_sample_value),
        .i_target_col   (i_target_col),
        .i_target_row   (i_target_row),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_item       (q_in)
    );

    bhr_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bhr_back #(
        .MAX_SIDE    (MAX_SIDE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_item  (q_out),
        .o_q_pop   (q_pop),
        .o_strobe  (o_strobe),
        .o_height  (o_height)
    );

endmodule

FILE: hdl/bhr_front.sv
// Front end: configuration registers, item capture, source position multiply.
// Depends on bhr_pkg; feeds bhr_queue.
module bhr_front import bhr_pkg::*; #(
    parameter int MAX_SIDE    = DEF_MAX_SIDE,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic                   i_operation,
    input  logic [COORD_W-1:0]     i_source_col,
    input  logic [COORD_W-1:0]     i_source_row,
    input  logic [VALUE_W-1:0]     i_sample_value,
    input  logic [TARGET_W-1:0]    i_target_col,
    input  logic [TARGET_W-1:0]    i_target_row,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output logic [1 + 2*$clog2(MAX_SIDE) + SAMPLE_BITS + 2*$clog2(MAX_SIDE+1)
                  + 2*(TARGET_W+STEP_W)-1:0] o_q_item
);

    localparam int AW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int POS_W = TARGET_W + STEP_W;

    logic [SIZE_W-1:0]   r_src_cols, r_src_rows;
    logic [STEP_W-1:0]   r_step_x, r_step_y;
    logic                r_valid;
    logic                r_op;
    logic [COORD_W-1:0]  r_col, r_row;
    logic [VALUE_W-1:0]  r_val;
    logic [TARGET_W-1:0] r_tc, r_tr;

    logic                accept, in_range;
    logic [31:0]         cols32, rows32, side_x32, side_y32;
    logic [POS_W-1:0]    pos_x, pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cols <= SIZE_RESET;
            r_src_rows <= SIZE_RESET;
            r_step_x   <= STEP_RESET;
            r_step_y   <= STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_COLUMNS: r_src_cols <= i_cfg_data[SIZE_W-1:0];
                CFG_SOURCE_ROWS:    r_src_rows <= i_cfg_data[SIZE_W-1:0];
                CFG_STEP_X:         r_step_x   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:         r_step_y   <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = r_valid && i_q_full;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_operation;
            r_col <= i_source_col;
            r_row <= i_source_row;
            r_val <= i_sample_value;
            r_tc  <= i_target_col;
            r_tr  <= i_target_row;
        end
    end

    always_comb begin
        in_range = (32'(r_col) < 32'(MAX_SIDE)) && (32'(r_row) < 32'(MAX_SIDE));
        cols32   = 32'(r_src_cols);
        rows32   = 32'(r_src_rows);
        side_x32 = (cols32 < 32'd2) ? 32'd2 :
                   (cols32 > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : cols32;
        side_y32 = (rows32 < 32'd2) ? 32'd2 :
                   (rows32 > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : rows32;
        pos_x    = POS_W'(r_tc) * POS_W'(r_step_x);
        pos_y    = POS_W'(r_tr) * POS_W'(r_step_y);
    end

    // writes outside the store are dropped here
    assign o_q_push = r_valid && !i_q_full && ((r_op == OP_COMPUTE) || in_range);

    assign o_q_item = {r_op, AW'(32'(r_row)), AW'(32'(r_col)), SAMPLE_BITS'(r_val),
                       SW'(side_x32), SW'(side_y32), pos_x, pos_y};

endmodule

FILE: hdl/bhr_queue.sv
// Two-entry item queue between the front end and the compute back end.
// Depends on bhr_pkg for the default width; the parent sets the width.
module bhr_queue import bhr_pkg::*; #(
    parameter int WIDTH = 2 * STEP_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PW'(1);
            if (i_pop)  r_rd <= r_rd + PW'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

FILE: hdl/bhr_back.sv
// Back end: frame store, 4x4 window fetch, shared Catmull-Rom unit, round and clamp.
// Depends on bhr_pkg; pops items from bhr_queue.
module bhr_back import bhr_pkg::*; #(
    parameter int MAX_SIDE    = DEF_MAX_SIDE,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  logic [1 + 2*$clog2(MAX_SIDE) + SAMPLE_BITS + 2*$clog2(MAX_SIDE+1)
                  + 2*(TARGET_W+STEP_W)-1:0] i_q_item,
    output logic                o_q_pop,
    output logic                o_strobe,
    output logic [HEIGHT_W-1:0] o_height
);

    localparam int AW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int POS_W = TARGET_W + STEP_W;
    localparam int BW    = POS_W - FRAC_BITS;
    localparam int IW    = BW + 2;
    localparam int RW    = SAMPLE_BITS + GUARD_BITS + 6;
    localparam int CW    = RW + 5;
    localparam int MW    = CW + FRAC_BITS + 1;
    localparam int XW    = CW + FRAC_BITS + 2;
    localparam int DEPTH = 1 << (2 * AW);

    logic                   h_op;
    logic [2*AW-1:0]        h_addr;
    logic [SAMPLE_BITS-1:0] h_val;
    logic [SW-1:0]          h_sx, h_sy;
    logic [BW-1:0]          h_bx, h_by;
    logic [FRAC_BITS-1:0]   h_fx, h_fy;

    assign {h_op, h_addr, h_val, h_sx, h_sy, h_bx, h_fx, h_by, h_fy} = i_q_item;

    t_back_state r_state, n_state;
    logic        mem_we;
    logic [2*AW-1:0] mem_addr;

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic                   r_rd_v;

    logic [3:0]          r_cnt;
    logic [2:0]          r_cub;
    logic [1:0]          r_stp;
    logic                r_strobe;
    logic [HEIGHT_W-1:0] r_height;

    logic [BW-1:0]          r_bx, r_by;
    logic [FRAC_BITS-1:0]   r_fx, r_fy;
    logic [SW-1:0]          r_sx, r_sy;
    logic [SAMPLE_BITS-1:0] r_lo, r_hi;
    logic [SAMPLE_BITS-1:0] r_win [16];
    logic signed [RW-1:0]   r_rows [4];
    logic signed [CW-1:0]   r_p [4];
    logic signed [CW-1:0]   r_h;
    logic signed [XW-1:0]   r_x;

    logic                   col_pass;
    logic [FRAC_BITS-1:0]   f;
    logic signed [MW-1:0]   f_s, m;
    logic signed [CW-1:0]   a, b, c, opnd;
    logic signed [XW-1:0]   x, yr, y_cl, lo_s, hi_s;

    function automatic logic [AW-1:0] clamp_idx(input logic [BW-1:0] base,
                                                 input logic [1:0] k,
                                                 input logic [SW-1:0] side);
        logic signed [IW-1:0] t;
        logic signed [IW-1:0] lim;
        t   = signed'(IW'(base)) + signed'(IW'(k)) - IW'(1);
        lim = signed'(IW'(side)) - IW'(1);
        if (t < 0) t = '0;
        else if (t > lim) t = lim;
        return AW'(t);
    endfunction

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        mem_we  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (h_op == OP_WRITE) mem_we = 1'b1;
                    else n_state = B_READ;
                end
            end
            B_READ:  if (&r_cnt) n_state = B_DRAIN;
            B_DRAIN: n_state = B_CALC;
            B_CALC:  if ((&r_stp) && col_pass) n_state = B_ROUND;
            B_ROUND: n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    assign mem_addr = (r_state == B_IDLE) ? h_addr :
                      {clamp_idx(r_by, r_cnt[3:2], r_sy), clamp_idx(r_bx, r_cnt[1:0], r_sx)};

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= h_val;
        r_rd <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_cnt    <= '0;
            r_cub    <= '0;
            r_stp    <= '0;
            r_rd_v   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_v   <= (r_state == B_READ);
            r_strobe <= (r_state == B_ROUND);
            if (r_state == B_READ) r_cnt <= r_cnt + 4'd1;
            else r_cnt <= '0;
            if (r_state == B_CALC) begin
                r_stp <= r_stp + 2'd1;
                if (&r_stp) r_cub <= r_cub + 3'd1;
            end else begin
                r_stp <= '0;
                r_cub <= '0;
            end
        end
    end

    // shared cubic unit: one multiply per step, Horner order c, b, a
    always_comb begin
        col_pass = (r_cub == COL_PASS);
        f    = col_pass ? r_fy : r_fx;
        f_s  = signed'(MW'(f));
        c    = CW'(-r_p[0] + 3 * r_p[1] - 3 * r_p[2] + r_p[3]);
        b    = CW'(2 * r_p[0] - 5 * r_p[1] + 4 * r_p[2] - r_p[3]);
        a    = CW'(r_p[2] - r_p[0]);
        opnd = (r_stp == 2'd1) ? c : r_h;
        m    = MW'(opnd) * f_s;
        x    = XW'(m) + (XW'(r_p[1]) <<< (FRAC_BITS + 1));
        yr   = (r_x + (XW'(1) <<< (FRAC_BITS + GUARD_BITS))) >>> (FRAC_BITS + 1 + GUARD_BITS);
        lo_s = signed'(XW'(r_lo));
        hi_s = signed'(XW'(r_hi));
        y_cl = (yr < lo_s) ? lo_s : (yr > hi_s) ? hi_s : yr;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && (h_op == OP_COMPUTE)) begin
            r_bx <= h_bx;
            r_by <= h_by;
            r_fx <= h_fx;
            r_fy <= h_fy;
            r_sx <= h_sx;
            r_sy <= h_sy;
            r_lo <= '1;
            r_hi <= '0;
        end
        if (r_rd_v) begin
            for (int i = 0; i < 15; i++) r_win[i] <= r_win[i+1];
            r_win[15] <= r_rd;
            if (r_rd < r_lo) r_lo <= r_rd;
            if (r_rd > r_hi) r_hi <= r_rd;
        end
        if (r_state == B_CALC) begin
            case (r_stp)
                2'd0: begin
                    if (col_pass) begin
                        for (int j = 0; j < 4; j++) r_p[j] <= CW'(r_rows[j]);
                    end else begin
                        for (int j = 0; j < 4; j++) r_p[j] <= signed'(CW'(r_win[j]));
                        for (int i = 0; i < 12; i++) r_win[i] <= r_win[i+4];
                    end
                end
                2'd1: r_h <= CW'(m >>> FRAC_BITS) + b;
                2'd2: r_h <= CW'(m >>> FRAC_BITS) + a;
                default: begin
                    if (col_pass) begin
                        r_x <= x;
                    end else begin
                        for (int i = 0; i < 3; i++) r_rows[i] <= r_rows[i+1];
                        r_rows[3] <= RW'(x >>> (FRAC_BITS + 1 - GUARD_BITS));
                    end
                end
            endcase
        end
        if (r_state == B_ROUND) r_height <= HEIGHT_W'(y_cl);
    end

    assign o_strobe = r_strobe;
    assign o_height = r_height;

endmodule

FILE: tb/bicubic_height_resampler_unit_test.sv
// Testbench of bicubic_height_resampler_unit: fills the source frame, asks for target heights,
// and checks each height against a bicubic interpolator kept in this file.
// Depends on bhr_pkg and the RTL of the block.
module bicubic_height_resampler_unit_test;
    import bhr_pkg::*;

    typedef struct packed {
        logic                op;
        logic [COORD_W-1:0]  scol;
        logic [COORD_W-1:0]  srow;
        logic [VALUE_W-1:0]  val;
        logic [TARGET_W-1:0] tcol;
        logic [TARGET_W-1:0] trow;
    } t_item;

    localparam int ITEM_BITS = $bits(t_item);

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_operation;
    logic [COORD_W-1:0]     i_source_col;
    logic [COORD_W-1:0]     i_source_row;
    logic [VALUE_W-1:0]     i_sample_value;
    logic [TARGET_W-1:0]    i_target_col;
    logic [TARGET_W-1:0]    i_target_row;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   o_strobe;
    logic [HEIGHT_W-1:0]    o_height;

    bicubic_height_resampler_unit dut (.*);

    t_item               pending_items[$];
    logic [HEIGHT_W-1:0] expected_heights[$];
    logic [VALUE_W-1:0]  height_store[0:65535];
    logic [SIZE_W-1:0]   cols_reg, rows_reg;
    logic [STEP_W-1:0]   step_x_reg, step_y_reg;
    int                  errors = 0;
    int                  heights_seen = 0;
    int                  writes_taken = 0;
    int                  gap_left = 0;
    bit                  quiet = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report(string what, logic [HEIGHT_W-1:0] got, logic [HEIGHT_W-1:0] want);
        $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint cr_eval(longint p0, longint p1, longint p2, longint p3,
                                       longint f);
        longint c, b, a, h;
        c = -p0 + 3 * p1 - 3 * p2 + p3;
        b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        a = p2 - p0;
        h = ((c * f) >>> DEF_FRAC_BITS) + b;
        h = ((h * f) >>> DEF_FRAC_BITS) + a;
        return h * f + p1 * (longint'(1) << (DEF_FRAC_BITS + 1));
    endfunction

    function automatic longint eff_side(logic [SIZE_W-1:0] n);
        if (n < 2) return 2;
        if (n > DEF_MAX_SIDE) return DEF_MAX_SIDE;
        return n;
    endfunction

    function automatic logic [HEIGHT_W-1:0] interp_height(logic [TARGET_W-1:0] tc,
                                                          logic [TARGET_W-1:0] tr);
        longint px, py, fx, fy, lo, hi, y, i, sc, sr;
        longint xi[4], yi[4], v[4], rv[4];
        px = longint'(tc) * longint'(step_x_reg);
        py = longint'(tr) * longint'(step_y_reg);
        fx = px & 64'hFFFF;
        fy = py & 64'hFFFF;
        sc = eff_side(cols_reg);
        sr = eff_side(rows_reg);
        for (int k = 0; k < 4; k++) begin
            i = (px >>> DEF_FRAC_BITS) + k - 1;
            xi[k] = (i > sc - 1) ? sc - 1 : (i < 0 ? 0 : i);
            i = (py >>> DEF_FRAC_BITS) + k - 1;
            yi[k] = (i > sr - 1) ? sr - 1 : (i < 0 ? 0 : i);
        end
        lo = 64'h7FFF_FFFF_FFFF_FFFF;
        hi = -1;
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
                v[k] = height_store[yi[r] * DEF_MAX_SIDE + xi[k]];
                if (v[k] < lo) lo = v[k];
                if (v[k] > hi) hi = v[k];
            end
            rv[r] = cr_eval(v[0], v[1], v[2], v[3], fx) >>> (DEF_FRAC_BITS + 1 - GUARD_BITS);
        end
        y = cr_eval(rv[0], rv[1], rv[2], rv[3], fy);
        y = (y + (longint'(1) << (DEF_FRAC_BITS + GUARD_BITS)))
            >>> (DEF_FRAC_BITS + 1 + GUARD_BITS);
        if (y < lo) y = lo;
        if (y > hi) y = hi;
        return y[HEIGHT_W-1:0];
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                if (i_operation == OP_WRITE) begin
                    height_store[{i_source_row, i_source_col}] = i_sample_value;
                    writes_taken++;
                end else begin
                    expected_heights.push_back(interp_height(i_target_col, i_target_row));
                end
                if (!quiet && $urandom_range(0, 9) == 0) gap_left = int'($urandom_range(1, 6));
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    start          <= 1'b1;
                    i_operation    <= nxt.op;
                    i_source_col   <= nxt.scol;
                    i_source_row   <= nxt.srow;
                    i_sample_value <= nxt.val;
                    i_target_col   <= nxt.tcol;
                    i_target_row   <= nxt.trow;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            heights_seen++;
            if (expected_heights.size() == 0)
                report("unexpected height", o_height, '0);
            else
                if (o_height !== expected_heights[0])
                    report("height", o_height, expected_heights[0]);
            if (expected_heights.size() > 0) void'(expected_heights.pop_front());
        end
    end

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SOURCE_COLUMNS: cols_reg   = data[SIZE_W-1:0];
            CFG_SOURCE_ROWS:    rows_reg   = data[SIZE_W-1:0];
            CFG_STEP_X:         step_x_reg = data;
            CFG_STEP_Y:         step_y_reg = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() > 0 || start || expected_heights.size() > 0);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic t_item rand_item(bit compute, int sc, int sr);
        t_item it;
        it = ITEM_BITS'({$urandom, $urandom});
        it.op   = compute ? OP_COMPUTE : OP_WRITE;
        it.val  = pick_value();
        it.scol = COORD_W'($urandom_range(0, sc - 1));
        it.srow = COORD_W'($urandom_range(0, sr - 1));
        if ($urandom_range(0, 1)) begin
            it.tcol = TARGET_W'($urandom_range(0, 15));
            it.trow = TARGET_W'($urandom_range(0, 15));
        end
        return it;
    endfunction

    task automatic run_phase(logic [CFG_DATA_W-1:0] c, logic [CFG_DATA_W-1:0] r,
                             logic [CFG_DATA_W-1:0] sx, logic [CFG_DATA_W-1:0] sy, int n);
        int sc, sr;
        t_item it;
        drain();
        cfg_write(CFG_SOURCE_COLUMNS, c);
        cfg_write(CFG_SOURCE_ROWS, r);
        cfg_write(CFG_STEP_X, sx);
        cfg_write(CFG_STEP_Y, sy);
        cfg_write(3'(4 + $urandom_range(0, 3)), CFG_DATA_W'($urandom));
        sc = int'(eff_side(c[SIZE_W-1:0]));
        sr = int'(eff_side(r[SIZE_W-1:0]));
        for (int y = 0; y < sr; y++)
            for (int x = 0; x < sc; x++) begin
                it = rand_item(0, sc, sr);
                it.scol = COORD_W'(x);
                it.srow = COORD_W'(y);
                pending_items.push_back(it);
            end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                it = rand_item(0, 256, 256);
                it.scol = COORD_W'(sc + $urandom_range(0, 255 - sc));
                pending_items.push_back(it);
            end else begin
                pending_items.push_back(rand_item($urandom_range(0, 9) < 7, sc, sr));
            end
        end
    endtask

    initial begin
        t_item it;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = 1'b0;
        i_source_col = '0;
        i_source_row = '0;
        i_sample_value = '0;
        i_target_col = '0;
        i_target_row = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cols_reg = SIZE_RESET;
        rows_reg = SIZE_RESET;
        step_x_reg = STEP_RESET;
        step_y_reg = STEP_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 4x4 frame, half step, corner and edge targets
        run_phase(24'd4, 24'd4, 24'h8000, 24'h8000, 0);
        for (int k = 0; k < 12; k++) begin
            it = rand_item(1, 4, 4);
            it.tcol = (k % 3 == 0) ? 12'd0 : (k % 3 == 1 ? 12'hFFF : 12'(k));
            it.trow = (k % 4 == 0) ? 12'd0 : (k % 4 == 1 ? 12'hFFF : 12'(k / 2));
            pending_items.push_back(it);
        end
        run_phase(24'd0, 24'd1, 24'h4000, 24'hFFFFFF, 20);
        run_phase(24'd256, 24'd2, 24'h10000, 24'h100, 120);
        run_phase(24'd2, 24'd511, 24'd0, 24'hFF0000, 120);
        for (int p = 0; p < 6; p++) begin
            if (p == 5) begin
                drain();
                quiet = 1;
            end
            run_phase(CFG_DATA_W'($urandom_range(2, 12)), CFG_DATA_W'($urandom_range(2, 12)),
                      $urandom_range(0, 3) == 0 ? CFG_DATA_W'($urandom_range(0, 24'hFF0000))
                                                : CFG_DATA_W'($urandom_range(0, 24'h40000)),
                      $urandom_range(0, 3) == 0 ? CFG_DATA_W'($urandom_range(0, 24'hFF0000))
                                                : CFG_DATA_W'($urandom_range(0, 24'h40000)),
                      70);
        end
        drain();
        $display("%0d sample writes and %0d heights checked over ten frame settings",
                 writes_taken, heights_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/bhr_pkg.sv
hdl/bhr_front.sv
hdl/bhr_queue.sv
hdl/bhr_back.sv
hdl/bicubic_height_resampler_unit.sv
tb/bicubic_height_resampler_unit_test.sv
